@@ rtl/ofr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ofr_pkg;

  // request codes
  localparam logic [2:0] REQ_PIXEL   = 3'd0;
  localparam logic [2:0] REQ_CLEAR   = 3'd1;
  localparam logic [2:0] REQ_REFRESH = 3'd2;
  localparam logic [2:0] REQ_ON      = 3'd3;
  localparam logic [2:0] REQ_OFF     = 3'd4;
  localparam logic [2:0] REQ_INIT    = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_CONTRAST  = 3'd0;
  localparam logic [2:0] CFG_CLKDIV    = 3'd1;
  localparam logic [2:0] CFG_MUX       = 3'd2;
  localparam logic [2:0] CFG_PRECHARGE = 3'd3;
  localparam logic [2:0] CFG_VCOMH     = 3'd4;

  // panel command bytes for the refresh stream
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  localparam int PC_W = 6;

  // program entry points
  localparam logic [PC_W-1:0] PC_PIXEL   = 6'd0;
  localparam logic [PC_W-1:0] PC_REFRESH = 6'd2;
  localparam logic [PC_W-1:0] PC_CLEAR   = 6'd4;
  localparam logic [PC_W-1:0] PC_ON      = 6'd5;
  localparam logic [PC_W-1:0] PC_OFF     = 6'd8;
  localparam logic [PC_W-1:0] PC_INIT    = 6'd11;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_CONTRAST,
    SRC_CLKDIV,
    SRC_MUX,
    SRC_PRECH,
    SRC_VCOMH,
    SRC_REFRESH
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] cbyte;
    logic       emit;
    logic       last;
    logic       rd;        // issue a store read
    logic       addr_cur;  // read address from the refresh cursor
    logic       chk;       // end the program if the pixel is off the panel
    logic       wr;        // write back the modified word
    logic       wipe;
    logic       done;
  } ctrl_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic wipe;
  } store_ctl_t;

  localparam ctrl_t CTRL_NOP = '{src: SRC_CONST, cbyte: 8'h00, emit: 1'b0, last: 1'b0,
                                 rd: 1'b0, addr_cur: 1'b0, chk: 1'b0, wr: 1'b0,
                                 wipe: 1'b0, done: 1'b0};

  function automatic ctrl_t emit_w(src_t s, logic [7:0] b, logic fin);
    ctrl_t c;
    c       = CTRL_NOP;
    c.src   = s;
    c.cbyte = b;
    c.emit  = 1'b1;
    c.last  = fin;
    c.done  = fin;
    return c;
  endfunction

  function automatic ctrl_t emit_c(logic [7:0] b);
    return emit_w(SRC_CONST, b, 1'b0);
  endfunction

  // control store
  function automatic ctrl_t rom(logic [PC_W-1:0] pc);
    ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      6'd0:  begin c.rd = 1'b1; c.chk = 1'b1; end
      6'd1:  begin c.wr = 1'b1; c.done = 1'b1; end
      6'd2:  begin c.rd = 1'b1; c.addr_cur = 1'b1; end
      6'd3:  c = emit_w(SRC_REFRESH, 8'h00, 1'b1);
      6'd4:  begin c.wipe = 1'b1; c.done = 1'b1; end
      6'd5:  c = emit_c(8'h8D);
      6'd6:  c = emit_c(8'h14);
      6'd7:  c = emit_w(SRC_CONST, 8'hAF, 1'b1);
      6'd8:  c = emit_c(8'h8D);
      6'd9:  c = emit_c(8'h10);
      6'd10: c = emit_w(SRC_CONST, 8'hAE, 1'b1);
      6'd11: begin c = emit_c(8'hAE); c.wipe = 1'b1; end
      6'd12: c = emit_c(8'hD5);
      6'd13: c = emit_w(SRC_CLKDIV, 8'h00, 1'b0);
      6'd14: c = emit_c(8'hA8);
      6'd15: c = emit_w(SRC_MUX, 8'h00, 1'b0);
      6'd16: c = emit_c(8'hD3);
      6'd17: c = emit_c(8'h00);
      6'd18: c = emit_c(8'h40);
      6'd19: c = emit_c(8'h8D);
      6'd20: c = emit_c(8'h14);
      6'd21: c = emit_c(8'h20);
      6'd22: c = emit_c(8'h02);
      6'd23: c = emit_c(8'hA1);
      6'd24: c = emit_c(8'hC0);
      6'd25: c = emit_c(8'hDA);
      6'd26: c = emit_c(8'h12);
      6'd27: c = emit_c(8'h81);
      6'd28: c = emit_w(SRC_CONTRAST, 8'h00, 1'b0);
      6'd29: c = emit_c(8'hD9);
      6'd30: c = emit_w(SRC_PRECH, 8'h00, 1'b0);
      6'd31: c = emit_c(8'hDB);
      6'd32: c = emit_w(SRC_VCOMH, 8'h00, 1'b0);
      6'd33: c = emit_c(8'hA4);
      6'd34: c = emit_c(8'hA6);
      6'd35: c = emit_w(SRC_CONST, 8'hAF, 1'b1);
      default: c.done = 1'b1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ofr_frame_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ofr_frame_store #(
  parameter int COLUMNS = 128,
  parameter int WORD_W  = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ofr_pkg::store_ctl_t        ctl,
  input  wire logic [$clog2(COLUMNS)-1:0] rd_addr,
  input  wire logic [$clog2(COLUMNS)-1:0] wr_addr,
  input  wire logic [WORD_W-1:0]          wr_data,
  output logic      [WORD_W-1:0]          rd_word
);

  logic [WORD_W-1:0]  mem [COLUMNS];
  logic [COLUMNS-1:0] valid_r;
  logic [WORD_W-1:0]  mem_q_r;
  logic               valid_q_r;

  // per-column valid bits stand in for a cleared store
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.wipe) begin
      valid_r <= '0;
    end else if (ctl.wr) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      mem_q_r   <= mem[rd_addr];
      valid_q_r <= valid_r[rd_addr];
    end
  end

  assign rd_word = valid_q_r ? mem_q_r : '0;

endmodule

`default_nettype wire

@@ rtl/oled_framebuffer_refresh_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// frame store and panel byte stream for a page-addressed monochrome oled
// input channel (in_valid/in_ready): one request per transfer, pixel write,
// clear, refresh step, display on, display off or init; codes 6 and 7 are
// taken and dropped
// output channel (out_valid/out_ready): one panel byte per transfer with its
// d/c level, a flag on the last byte of a request and a frame end flag
// a request is taken only while the sequencer is idle; each request runs its
// microcode program: pixel write reads then writes one store word (ending
// before the read when off the panel), refresh step reads the store then
// emits, other requests run their own programs, unknown codes run none, each
// emit step also waiting while the output register is full and not drained
// the first byte shows on the output in the cycle after its emit step
// reset (synchronous, rst_n low) clears the store through per-column valid
// bits, the refresh cursor and the output register, and loads the register
// defaults; no clearing pass is needed
// a stalled receiver holds the sequencer on its emit step, nothing is lost
// configuration writes are taken at once and belong in idle periods
module oled_framebuffer_refresh_top #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_px_x,
  input  wire logic [7:0] in_px_y,
  input  wire logic       in_pixel_on,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_byte,
  output logic            out_is_data,
  output logic            out_run_last,
  output logic            out_frame_end,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int WORD_W = PAGES * 8;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int SLOT_W = $clog2(COLUMNS + 3);

  // configuration registers
  logic [7:0] contrast_r, clkdiv_r, precharge_r, vcomh_r;
  logic [5:0] mux_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r  <= 8'd239;
      clkdiv_r    <= 8'd80;
      mux_r       <= 6'd63;
      precharge_r <= 8'd241;
      vcomh_r     <= 8'd48;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ofr_pkg::CFG_CONTRAST:  contrast_r  <= cfg_data;
        ofr_pkg::CFG_CLKDIV:    clkdiv_r    <= cfg_data;
        ofr_pkg::CFG_MUX:       mux_r       <= cfg_data[5:0];
        ofr_pkg::CFG_PRECHARGE: precharge_r <= cfg_data;
        ofr_pkg::CFG_VCOMH:     vcomh_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic                     busy_r, busy_nxt;
  logic [ofr_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic [7:0]               x_r, y_r;
  logic                     on_r;
  logic [2:0]               page_r, page_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;

  ofr_pkg::ctrl_t ctrl;
  logic           stall, step_go, in_xfer, oor, finish;
  logic [ofr_pkg::PC_W-1:0] entry_pc;
  logic           entry_ok;

  assign ctrl     = ofr_pkg::rom(pc_r);
  assign in_ready = !busy_r;
  assign in_xfer  = in_valid && in_ready;
  assign stall    = ctrl.emit && out_valid && !out_ready;
  assign step_go  = busy_r && !stall;

  // pixel off the panel ends the program before the read
  assign oor = ({1'b0, x_r} >= 9'(COLUMNS)) || ({1'b0, y_r} >= 9'(WORD_W));
  assign finish = ctrl.done || (ctrl.chk && oor);

  always_comb begin
    entry_ok = 1'b1;
    case (in_req_type)
      ofr_pkg::REQ_PIXEL:   entry_pc = ofr_pkg::PC_PIXEL;
      ofr_pkg::REQ_CLEAR:   entry_pc = ofr_pkg::PC_CLEAR;
      ofr_pkg::REQ_REFRESH: entry_pc = ofr_pkg::PC_REFRESH;
      ofr_pkg::REQ_ON:      entry_pc = ofr_pkg::PC_ON;
      ofr_pkg::REQ_OFF:     entry_pc = ofr_pkg::PC_OFF;
      ofr_pkg::REQ_INIT:    entry_pc = ofr_pkg::PC_INIT;
      default: begin
        entry_pc = ofr_pkg::PC_PIXEL;
        entry_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (in_xfer) begin
      busy_nxt = entry_ok;
      pc_nxt   = entry_pc;
    end else if (step_go) begin
      busy_nxt = !finish;
      pc_nxt   = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= ofr_pkg::PC_PIXEL;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r  <= in_px_x;
      y_r  <= in_px_y;
      on_r <= in_pixel_on;
    end
  end

  // frame store
  ofr_pkg::store_ctl_t sctl;
  logic [COL_W-1:0]    rd_addr, cur_col;
  logic [WORD_W-1:0]   rd_word, wr_word, mask;
  logic [2:0]          px_page;
  logic [5:0]          bit_full;

  assign sctl = '{rd:   step_go && ctrl.rd && !(ctrl.chk && oor),
                  wr:   step_go && ctrl.wr,
                  wipe: step_go && ctrl.wipe};

  assign cur_col = COL_W'(slot_r - SLOT_W'(3));
  assign rd_addr = ctrl.addr_cur ? cur_col : x_r[COL_W-1:0];

  // page counts from the bottom of the panel, bit from the top of the byte
  assign px_page  = 3'(PAGES - 1) - y_r[5:3];
  assign bit_full = {px_page, ~y_r[2:0]};
  assign mask     = {{(WORD_W-1){1'b0}}, 1'b1} << bit_full[BIT_W-1:0];
  assign wr_word  = on_r ? (rd_word | mask) : (rd_word & ~mask);

  ofr_frame_store #(
    .COLUMNS (COLUMNS),
    .WORD_W  (WORD_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sctl),
    .rd_addr (rd_addr),
    .wr_addr (x_r[COL_W-1:0]),
    .wr_data (wr_word),
    .rd_word (rd_word)
  );

  // refresh stream byte and cursor
  logic [7:0] ref_byte, emit_byte;
  logic       ref_data, last_slot, last_page, ref_fend;

  assign last_slot = slot_r == SLOT_W'(COLUMNS + 2);
  assign last_page = page_r == 3'(PAGES - 1);
  assign ref_data  = slot_r >= SLOT_W'(3);
  assign ref_fend  = last_slot && last_page;

  always_comb begin
    if (slot_r == SLOT_W'(0)) begin
      ref_byte = ofr_pkg::CMD_PAGE_BASE + {5'd0, page_r};
    end else if (slot_r == SLOT_W'(1)) begin
      ref_byte = ofr_pkg::CMD_COL_LO;
    end else if (slot_r == SLOT_W'(2)) begin
      ref_byte = ofr_pkg::CMD_COL_HI;
    end else begin
      ref_byte = 8'(rd_word >> {page_r, 3'b000});
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    page_nxt = page_r;
    if (sctl.wipe) begin
      slot_nxt = '0;
      page_nxt = '0;
    end else if (step_go && ctrl.emit && ctrl.src == ofr_pkg::SRC_REFRESH) begin
      if (last_slot) begin
        slot_nxt = '0;
        page_nxt = last_page ? 3'd0 : page_r + 3'd1;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      page_r <= '0;
    end else begin
      slot_r <= slot_nxt;
      page_r <= page_nxt;
    end
  end

  always_comb begin
    case (ctrl.src)
      ofr_pkg::SRC_CONST:    emit_byte = ctrl.cbyte;
      ofr_pkg::SRC_CONTRAST: emit_byte = contrast_r;
      ofr_pkg::SRC_CLKDIV:   emit_byte = clkdiv_r;
      ofr_pkg::SRC_MUX:      emit_byte = {2'b00, mux_r};
      ofr_pkg::SRC_PRECH:    emit_byte = precharge_r;
      ofr_pkg::SRC_VCOMH:    emit_byte = vcomh_r;
      ofr_pkg::SRC_REFRESH:  emit_byte = ref_byte;
      default:               emit_byte = ctrl.cbyte;
    endcase
  end

  // output register, refilled in the cycle it drains
  logic out_valid_r, load;
  logic [7:0] out_byte_r;
  logic out_is_data_r, out_run_last_r, out_frame_end_r;

  assign load = step_go && ctrl.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r      <= emit_byte;
      out_is_data_r   <= (ctrl.src == ofr_pkg::SRC_REFRESH) && ref_data;
      out_run_last_r  <= ctrl.last;
      out_frame_end_r <= (ctrl.src == ofr_pkg::SRC_REFRESH) && ref_fend;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_is_data   = out_is_data_r;
  assign out_run_last  = out_run_last_r;
  assign out_frame_end = out_frame_end_r;

endmodule

`default_nettype wire

@@ rtl/ofr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ofr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_req_type,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_is_data,
  input wire logic       out_run_last,
  input wire logic       out_frame_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_is_data)
      && $stable(out_run_last) && $stable(out_frame_end))
    else $error("stalled output changed");

  // a known request keeps the sequencer busy for at least one step
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type <= ofr_pkg::REQ_INIT) |=> !in_ready)
    else $error("request accepted while busy");

  // data bytes come only from single-byte refresh steps
  a_data_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_data |-> out_run_last)
    else $error("data byte not marked last");

  a_fend_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_is_data)
    else $error("frame end on a command byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind oled_framebuffer_refresh_top ofr_checker u_ofr_checker (.*);

`default_nettype wire
